[sv/assert_macros.svh]
// Assertion helpers shared by the RTL. Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset
`define PSP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be seen outside reset
`define PSP_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PSP_ASSERT(lbl, clk, rst, prop, msg)
`define PSP_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

[sv/psp_pkg.sv]
package psp_pkg;

   // Default length of the idle-period window
   localparam int HIST_DEPTH_DEF = 5;

   // Fixed window taps used by the predictor
   localparam int HIST_TAP_LIN = 1;
   localparam int HIST_TAP_SQ  = 2;

   localparam int DUR_W  = 24;
   localparam int TIME_W = 32;
   localparam int COEF_W = 32;
   localparam int IDX_W  = 3;

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Power state codes
   localparam logic [1:0] PS_ACTIVE = 2'd0;
   localparam logic [1:0] PS_IDLE   = 2'd1;
   localparam logic [1:0] PS_SLEEP  = 2'd2;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_POLICY    = 3'd0;
   localparam logic [IDX_W-1:0] REG_TO_IDLE   = 3'd1;
   localparam logic [IDX_W-1:0] REG_TO_SLEEP  = 3'd2;
   localparam logic [IDX_W-1:0] REG_COEF_SQ   = 3'd3;
   localparam logic [IDX_W-1:0] REG_COEF_LIN  = 3'd4;
   localparam logic [IDX_W-1:0] REG_COEF_CON  = 3'd5;
   localparam logic [IDX_W-1:0] REG_THR_IDLE  = 3'd6;
   localparam logic [IDX_W-1:0] REG_THR_SLEEP = 3'd7;

   // Clamp on the magnitude of the squared term, Q41.16 units
   localparam logic [56:0] SQ_LIMIT = 57'd1 << 56;

   typedef struct packed {
      logic              operation;
      logic [DUR_W-1:0]  idle_duration;
      logic [TIME_W-1:0] tick_time;
      logic [TIME_W-1:0] idle_start;
   } req_type;

   typedef struct packed {
      logic [1:0] power_state;
      logic       state_changed;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [COEF_W-1:0] value;
   } csr_type;

   // Controller to datapath commands
   typedef struct packed {
      logic push;
      logic capture;
      logic load_sq;
      logic load_plo;
      logic load_phi;
      logic load_lin;
      logic load_pred;
      logic decide_to;
      logic decide_hist;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic policy;
   } status_type;

endpackage

[sv/psp_chan_if.sv]
interface psp_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[sv/power_state_policy.sv]
// Channel  Dir  Payload                                         Handshake
// req_     in   operation, idle_duration, tick_time, idle_start valid/ready
// rsp_     out  power_state, state_changed                      valid/ready
// csr_     in   index, value                                    valid/ready (always ready)
//
// A push gives no result. A tick runs the timeout state under the timeout policy,
// and the square, product low/high, linear, predict and decide states under the
// history policy; the one 33x25 multiplier forms h[2]^2, the two partial products
// and the linear term. Reset clears the registers, window and previous state.
// The result waits in an output register; a following push is taken meanwhile,
// and a tick finishing while the result is still held stalls until it is taken.
`include "assert_macros.svh"

module power_state_policy #(
   parameter int HIST_DEPTH = psp_pkg::HIST_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   psp_chan_if.sink   req_chan,
   psp_chan_if.source rsp_chan,
   psp_chan_if.sink   csr_chan
);

   psp_pkg::cmd_type    cmd;
   psp_pkg::status_type status;
   psp_pkg::req_type    req_data;
   psp_pkg::csr_type    csr_data;
   psp_pkg::rsp_type    rsp_data;
   logic                req_ready;
   logic                rsp_valid;

   assign req_data       = req_chan.data;
   assign csr_data       = csr_chan.data;
   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.data  = rsp_data;

   psp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_data.operation),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   psp_dp #(
      .HIST_DEPTH (HIST_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .csr_we   (csr_chan.valid),
      .csr_data (csr_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // A tick holds off further items while it is being worked on
   `PSP_ASSERT(a_tick_blocks, clock, reset, (req_chan.valid && req_ready && req_data.operation == psp_pkg::OP_TICK) |=> !req_ready, "item accepted during a tick")
   // A push never raises a result
   `PSP_ASSERT(a_push_silent, clock, reset, (req_chan.valid && req_ready && req_data.operation == psp_pkg::OP_PUSH && !rsp_valid) |=> !rsp_valid, "push produced a result")
   // A result is never loaded over one that is still waiting
   `PSP_ASSERT_NEVER(a_no_overwrite, clock, reset, (cmd.decide_to || cmd.decide_hist) && rsp_valid && !rsp_chan.ready, "waiting result overwritten")

endmodule

[sv/psp_ctrl.sv]
module psp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  psp_pkg::status_type  status,
   output psp_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_TIMEOUT  = 3'd1;
   localparam logic [2:0] ST_SQUARE   = 3'd2;
   localparam logic [2:0] ST_PROD_LO  = 3'd3;
   localparam logic [2:0] ST_PROD_HI  = 3'd4;
   localparam logic [2:0] ST_LINEAR   = 3'd5;
   localparam logic [2:0] ST_PREDICT  = 3'd6;
   localparam logic [2:0] ST_DECIDE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Sequence one item through the datapath
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.push    = accept && (req_op == psp_pkg::OP_PUSH);
      cmd.capture = accept && (req_op == psp_pkg::OP_TICK);
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = status.policy ? ST_SQUARE : ST_TIMEOUT;
            end
         end
         ST_TIMEOUT: begin
            if (rsp_free) begin
               cmd.decide_to = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SQUARE: begin
            cmd.load_sq = 1'b1;
            state_in    = ST_PROD_LO;
         end
         ST_PROD_LO: begin
            cmd.load_plo = 1'b1;
            state_in     = ST_PROD_HI;
         end
         ST_PROD_HI: begin
            cmd.load_phi = 1'b1;
            state_in     = ST_LINEAR;
         end
         ST_LINEAR: begin
            cmd.load_lin = 1'b1;
            state_in     = ST_PREDICT;
         end
         ST_PREDICT: begin
            cmd.load_pred = 1'b1;
            state_in      = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               cmd.decide_hist = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until taken; a new load may replace a taken one
   always_comb begin
      if (cmd.decide_to || cmd.decide_hist) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/psp_dp.sv]
module psp_dp #(
   parameter int HIST_DEPTH = psp_pkg::HIST_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  psp_pkg::cmd_type     cmd,
   input  psp_pkg::req_type     req_data,
   input  logic                 csr_we,
   input  psp_pkg::csr_type     csr_data,
   output psp_pkg::status_type  status,
   output psp_pkg::rsp_type     rsp_data
);

   // Configuration registers
   logic               policy_ff, policy_in;
   logic [23:0]        to_idle_ff, to_idle_in;
   logic [23:0]        to_sleep_ff, to_sleep_in;
   logic signed [31:0] c_sq_ff, c_sq_in;
   logic signed [31:0] c_lin_ff, c_lin_in;
   logic signed [31:0] c_con_ff, c_con_in;
   logic [23:0]        th_idle_ff, th_idle_in;
   logic [23:0]        th_sleep_ff, th_sleep_in;

   // Window and item state
   logic [23:0]        hist_ff [HIST_DEPTH];
   logic [23:0]        hist_in [HIST_DEPTH];
   logic [1:0]         prev_ff, prev_in;
   logic [31:0]        now_ff, now_in;
   logic [31:0]        start_ff, start_in;

   // Prediction pipeline
   logic [31:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [47:0]        sq_ff, sq_in;
   logic [55:0]        plo_ff, plo_in;
   logic [55:0]        phi_ff, phi_in;
   logic signed [55:0] lin_ff, lin_in;
   logic [56:0]        magp_ff, magp_in;
   logic signed [58:0] pred_ff, pred_in;
   psp_pkg::rsp_type   rsp_ff, rsp_in;

   logic signed [32:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [57:0] mul_p;
   logic [79:0]        prod_full;
   logic signed [58:0] term_s;
   logic [32:0]        end_idle, end_sleep;
   logic [1:0]         to_st, hist_st, new_st;

   assign status.policy = policy_ff;
   assign rsp_data      = rsp_ff;

   // Shared multiplier: operands follow the step being run
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.load_sq) begin
         mul_a = $signed({9'd0, hist_ff[psp_pkg::HIST_TAP_SQ]});
         mul_b = $signed({1'b0, hist_ff[psp_pkg::HIST_TAP_SQ]});
      end else if (cmd.load_plo) begin
         mul_a = $signed({1'b0, mag_ff});
         mul_b = $signed({1'b0, sq_ff[23:0]});
      end else if (cmd.load_phi) begin
         mul_a = $signed({1'b0, mag_ff});
         mul_b = $signed({1'b0, sq_ff[47:24]});
      end else if (cmd.load_lin) begin
         mul_a = 33'(c_lin_ff);
         mul_b = $signed({1'b0, hist_ff[psp_pkg::HIST_TAP_LIN]});
      end
   end
   assign mul_p = mul_a * mul_b;

   // Combine partial products; the squared term magnitude is clamped as it is loaded
   assign prod_full = {phi_ff, 24'd0} + {24'd0, plo_ff};

   // Apply sign of the square coefficient
   assign term_s = neg_ff ? -$signed({2'b00, magp_ff}) : $signed({2'b00, magp_ff});

   // Timeout policy
   assign end_idle  = {1'b0, start_ff} + {9'd0, to_idle_ff};
   assign end_sleep = {1'b0, start_ff} + {9'd0, to_sleep_ff};
   always_comb begin
      if (!({1'b0, now_ff} > end_idle)) begin
         to_st = psp_pkg::PS_ACTIVE;
      end else if ((to_sleep_ff > to_idle_ff) && ({1'b0, now_ff} > end_sleep)) begin
         to_st = psp_pkg::PS_SLEEP;
      end else begin
         to_st = psp_pkg::PS_IDLE;
      end
   end

   // History policy
   always_comb begin
      if (now_ff < start_ff) begin
         hist_st = psp_pkg::PS_ACTIVE;
      end else if (pred_ff < $signed({19'd0, th_idle_ff, 16'd0})) begin
         hist_st = psp_pkg::PS_ACTIVE;
      end else if ((pred_ff >= $signed({19'd0, th_sleep_ff, 16'd0}))
                   && (th_sleep_ff > th_idle_ff)) begin
         hist_st = psp_pkg::PS_SLEEP;
      end else begin
         hist_st = psp_pkg::PS_IDLE;
      end
   end

   assign new_st = cmd.decide_to ? to_st : hist_st;

   // Next values
   always_comb begin
      policy_in   = policy_ff;
      to_idle_in  = to_idle_ff;
      to_sleep_in = to_sleep_ff;
      c_sq_in     = c_sq_ff;
      c_lin_in    = c_lin_ff;
      c_con_in    = c_con_ff;
      th_idle_in  = th_idle_ff;
      th_sleep_in = th_sleep_ff;
      hist_in     = hist_ff;
      prev_in     = prev_ff;
      now_in      = now_ff;
      start_in    = start_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      sq_in       = sq_ff;
      plo_in      = plo_ff;
      phi_in      = phi_ff;
      lin_in      = lin_ff;
      magp_in     = magp_ff;
      pred_in     = pred_ff;
      rsp_in      = rsp_ff;

      // Register writes
      if (csr_we) begin
         case (csr_data.index)
            psp_pkg::REG_POLICY:    policy_in   = csr_data.value[0];
            psp_pkg::REG_TO_IDLE:   to_idle_in  = csr_data.value[23:0];
            psp_pkg::REG_TO_SLEEP:  to_sleep_in = csr_data.value[23:0];
            psp_pkg::REG_COEF_SQ:   c_sq_in     = $signed(csr_data.value);
            psp_pkg::REG_COEF_LIN:  c_lin_in    = $signed(csr_data.value);
            psp_pkg::REG_COEF_CON:  c_con_in    = $signed(csr_data.value);
            psp_pkg::REG_THR_IDLE:  th_idle_in  = csr_data.value[23:0];
            psp_pkg::REG_THR_SLEEP: th_sleep_in = csr_data.value[23:0];
            default: begin
            end
         endcase
      end

      // Shift the window toward index 0, new length at the top
      if (cmd.push) begin
         for (int i = 0; i < HIST_DEPTH - 1; i++) begin
            hist_in[i] = hist_ff[i+1];
         end
         hist_in[HIST_DEPTH-1] = req_data.idle_duration;
      end

      if (cmd.capture) begin
         now_in   = req_data.tick_time;
         start_in = req_data.idle_start;
      end

      if (cmd.load_sq) begin
         sq_in  = mul_p[47:0];
         neg_in = c_sq_ff[31];
         mag_in = c_sq_ff[31] ? (~c_sq_ff + 32'd1) : c_sq_ff;
      end
      if (cmd.load_plo) begin
         plo_in = mul_p[55:0];
      end
      if (cmd.load_phi) begin
         phi_in = mul_p[55:0];
      end
      if (cmd.load_lin) begin
         lin_in  = mul_p[55:0];
         magp_in = (prod_full > {23'd0, psp_pkg::SQ_LIMIT}) ?
                   psp_pkg::SQ_LIMIT : prod_full[56:0];
      end
      if (cmd.load_pred) begin
         pred_in = term_s + 59'(lin_ff) + 59'(c_con_ff);
      end

      // Load the result and remember the chosen state
      if (cmd.decide_to || cmd.decide_hist) begin
         rsp_in.power_state   = new_st;
         rsp_in.state_changed = (new_st != prev_ff);
         prev_in              = new_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= 1'b0;
         to_idle_ff  <= '0;
         to_sleep_ff <= '0;
         c_sq_ff     <= '0;
         c_lin_ff    <= '0;
         c_con_ff    <= '0;
         th_idle_ff  <= '0;
         th_sleep_ff <= '0;
         prev_ff     <= psp_pkg::PS_ACTIVE;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         policy_ff   <= policy_in;
         to_idle_ff  <= to_idle_in;
         to_sleep_ff <= to_sleep_in;
         c_sq_ff     <= c_sq_in;
         c_lin_ff    <= c_lin_in;
         c_con_ff    <= c_con_in;
         th_idle_ff  <= th_idle_in;
         th_sleep_ff <= th_sleep_in;
         prev_ff     <= prev_in;
         hist_ff     <= hist_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      now_ff   <= now_in;
      start_ff <= start_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      sq_ff    <= sq_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      lin_ff   <= lin_in;
      magp_ff  <= magp_in;
      pred_ff  <= pred_in;
      rsp_ff   <= rsp_in;
   end

endmodule
